[rtl/mjwm_pkg.sv]
// ----------------------------------------------------------------------------
// mjwm_pkg
// Types and constants shared by the mecanum joystick wheel mixer.
// ----------------------------------------------------------------------------
package mjwm_pkg;

	// Joystick centre value and the symmetric limit of every axis and wheel.
	localparam logic [7:0] Centre = 8'd127;
	localparam logic [7:0] AxisLimit = 8'd127;

	// 45 degree rotation gain, 181/256 is about 0.7071.
	localparam logic [7:0] RotMul = 8'd181;

	// Dead band half width after reset.
	localparam logic [6:0] DeadBandReset = 7'd10;

	// One joystick sample.
	typedef struct packed {
		logic [7:0] stick_x;
		logic [7:0] stick_y;
		logic [7:0] stick_turn;
	} in_item_t;

	// Direction and duty for the four wheels.
	typedef struct packed {
		logic       front_left_reverse;
		logic [6:0] front_left_duty;
		logic       front_right_reverse;
		logic [6:0] front_right_duty;
		logic       rear_left_reverse;
		logic [6:0] rear_left_duty;
		logic       rear_right_reverse;
		logic [6:0] rear_right_duty;
	} out_item_t;

	// Drive command of one wheel.
	typedef struct packed {
		logic       reverse;
		logic [6:0] duty;
	} wheel_cmd_t;

endpackage

[rtl/mecanum_joystick_wheel_mixer.sv]
// ----------------------------------------------------------------------------
// mecanum_joystick_wheel_mixer
// Turns one joystick sample (x, y, turn) into direction and duty for the four
// wheels of a mecanum drive.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while the output is not
// stalled. A sample waits in the input register, then passes through the
// mixing logic into the output register, from which its wheel word leaves. The
// two stages stall independently, so a new sample is taken while a finished
// word still waits at the output. The dead band register may be written at
// any time the pipeline holds no sample; it applies to samples that reach the
// mixing logic afterwards.
module mecanum_joystick_wheel_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mjwm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mjwm_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic [6:0]          cfg_wr_data
);

	// Centre an axis, apply the dead band and clamp to the axis limit.
	function automatic logic signed [7:0] axis_value(input logic [7:0] raw,
			input logic invert, input logic [6:0] band);
		logic [7:0]        lo;
		logic [7:0]        hi;
		logic signed [8:0] d;
		logic signed [8:0] lim;
		lo  = mjwm_pkg::Centre - {1'b0, band};
		hi  = mjwm_pkg::Centre + {1'b0, band};
		lim = $signed({1'b0, mjwm_pkg::AxisLimit});
		if (invert) begin
			d = $signed({1'b0, mjwm_pkg::Centre}) - $signed({1'b0, raw});
		end else begin
			d = $signed({1'b0, raw}) - $signed({1'b0, mjwm_pkg::Centre});
		end
		if (raw > lo && raw < hi) begin
			return 8'sd0;
		end else if (d > lim) begin
			return lim[7:0];
		end else if (d < -lim) begin
			return 8'(-lim);
		end else begin
			return d[7:0];
		end
	endfunction

	// Scale by 181/256 with truncation toward zero.
	function automatic logic signed [8:0] rotate_scale(input logic signed [8:0] s);
		logic signed [8:0] neg;
		logic [7:0]        mag;
		logic [15:0]       prod;
		logic signed [8:0] q;
		neg  = -s;
		mag  = s[8] ? neg[7:0] : s[7:0];
		prod = {8'd0, mag} * {8'd0, mjwm_pkg::RotMul};
		q    = $signed({1'b0, prod[15:8]});
		return s[8] ? -q : q;
	endfunction

	// Clamp a wheel value and split it into direction and duty.
	function automatic mjwm_pkg::wheel_cmd_t wheel_cmd(input logic signed [9:0] v);
		logic signed [9:0]    lim;
		logic signed [7:0]    c;
		logic signed [7:0]    sum;
		mjwm_pkg::wheel_cmd_t w;
		lim = $signed({2'b00, mjwm_pkg::AxisLimit});
		if (v > lim) begin
			c = lim[7:0];
		end else if (v < -lim) begin
			c = 8'(-lim);
		end else begin
			c = v[7:0];
		end
		sum = c + $signed(mjwm_pkg::AxisLimit);
		if (c < 0) begin
			w.reverse = 1'b1;
			w.duty    = sum[6:0];
		end else begin
			w.reverse = 1'b0;
			w.duty    = c[6:0];
		end
		return w;
	endfunction

	logic [6:0]           dead_band_q;
	logic                 valid_s1;
	mjwm_pkg::in_item_t   data_s1;
	logic                 valid_s2;
	mjwm_pkg::out_item_t  data_s2;
	logic                 adv_s1;
	logic                 adv_s2;
	logic signed [7:0]    ax_x;
	logic signed [7:0]    ax_y;
	logic signed [7:0]    ax_t;
	logic signed [8:0]    rot_a;
	logic signed [8:0]    rot_b;
	logic signed [9:0]    left_v;
	logic signed [9:0]    right_v;
	mjwm_pkg::wheel_cmd_t left_cmd;
	mjwm_pkg::wheel_cmd_t right_cmd;
	mjwm_pkg::out_item_t  mix_word;

	// Dead band configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= mjwm_pkg::DeadBandReset;
		end else if (cfg_wr_en) begin
			dead_band_q <= cfg_wr_data;
		end
	end

	// Stage handshake: each stage moves when its downstream slot is free.
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign adv_s1   = in_valid && in_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Mixing logic between the input register and the output register.
	always_comb begin
		ax_x    = axis_value(data_s1.stick_x, 1'b0, dead_band_q);
		ax_y    = axis_value(data_s1.stick_y, 1'b1, dead_band_q);
		ax_t    = axis_value(data_s1.stick_turn, 1'b1, dead_band_q);
		rot_a   = rotate_scale(9'(ax_x) - 9'(ax_y));
		rot_b   = rotate_scale(9'(ax_x) + 9'(ax_y));
		left_v  = 10'(rot_a) + 10'(ax_t);
		right_v = 10'(rot_b) - 10'(ax_t);
		left_cmd  = wheel_cmd(left_v);
		right_cmd = wheel_cmd(right_v);
		mix_word.front_left_reverse  = left_cmd.reverse;
		mix_word.front_left_duty     = left_cmd.duty;
		mix_word.front_right_reverse = right_cmd.reverse;
		mix_word.front_right_duty    = right_cmd.duty;
		mix_word.rear_left_reverse   = left_cmd.reverse;
		mix_word.rear_left_duty      = left_cmd.duty;
		mix_word.rear_right_reverse  = right_cmd.reverse;
		mix_word.rear_right_duty     = right_cmd.duty;
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s1 <= in_data;
		end
		if (adv_s2) begin
			data_s2 <= mix_word;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

[tb/sv/mjwm_wheel_checker.sv]
// ----------------------------------------------------------------------------
// mjwm_wheel_checker
// Watches the joystick and wheel channels of the mecanum mixer, works out the
// wheel word due for every accepted joystick word and compares it with the
// word that leaves the block.
// ----------------------------------------------------------------------------
module mjwm_wheel_checker
	import mjwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  in_item_t   in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  out_item_t  out_data,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	output int         mismatches,
	output int         words_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StickMid = Centre;
	localparam int WheelLim = AxisLimit;
	localparam int TurnGain = RotMul;
	localparam int ReportMax = 10;

	// Names of the eight output fields, in the order they are packed.
	localparam string FieldName [8] = '{
		"front_left_reverse", "front_left_duty", "front_right_reverse", "front_right_duty",
		"rear_left_reverse", "rear_left_duty", "rear_right_reverse", "rear_right_duty"
	};

	logic [6:0] band_copy;
	out_item_t  wheels_due [$];
	out_item_t  due_word;
	int         due_field [8];
	int         seen_field [8];

	initial mismatches = 0;

	// Saturate a signed value to the symmetric axis and wheel limit.
	function automatic int clip_lim(int v);
		if (v > WheelLim) return WheelLim;
		if (v < -WheelLim) return -WheelLim;
		return v;
	endfunction

	// Centred axis value of one raw stick byte, zero inside the dead zone.
	function automatic int stick_axis(logic [7:0] raw, logic [6:0] band, bit inverted);
		int r;
		int b;
		r = raw;
		b = band;
		if (r > StickMid - b && r < StickMid + b) return 0;
		return clip_lim(inverted ? StickMid - r : r - StickMid);
	endfunction

	// Direction and duty for one wheel value.
	function automatic wheel_cmd_t wheel_drive(int v);
		wheel_cmd_t w;
		v = clip_lim(v);
		w.reverse = (v < 0);
		w.duty = (v < 0) ? 7'(WheelLim + v) : 7'(v);
		return w;
	endfunction

	// Wheel word for one joystick word under a given dead band.
	function automatic out_item_t wheel_word_for(in_item_t s, logic [6:0] band);
		int         x;
		int         y;
		int         t;
		int         diag_a;
		int         diag_b;
		wheel_cmd_t left;
		wheel_cmd_t right;
		x = stick_axis(s.stick_x, band, 1'b0);
		y = stick_axis(s.stick_y, band, 1'b1);
		t = stick_axis(s.stick_turn, band, 1'b1);
		// Signed division truncates toward zero, as the 45 degree turn needs.
		diag_a = (x - y) * TurnGain / 256;
		diag_b = (x + y) * TurnGain / 256;
		left = wheel_drive(diag_a + t);
		right = wheel_drive(diag_b - t);
		return {left, right, left, right};
	endfunction

	// Split a wheel word into its eight fields as integers.
	function automatic void split_word(out_item_t w, output int f [8]);
		wheel_cmd_t [3:0] cmd;
		cmd = w;
		for (int k = 0; k < 4; k++) begin
			f[2 * k] = cmd[3 - k].reverse;
			f[2 * k + 1] = cmd[3 - k].duty;
		end
	endfunction

	// Log a failure; only the first few are printed.
	function automatic void note_failure(string msg);
		if (mismatches < ReportMax) $display("%0t: %s", $realtime, msg);
		mismatches++;
	endfunction

	// Track the dead band, queue predictions and compare outgoing words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_copy = DeadBandReset;
			wheels_due.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (wheels_due.size() == 0) begin
					note_failure($sformatf("wheel word %h with no joystick word pending", out_data));
				end else begin
					due_word = wheels_due.pop_front();
					split_word(due_word, due_field);
					split_word(out_data, seen_field);
					for (int k = 0; k < 8; k++) begin
						if (due_field[k] != seen_field[k]) begin
							note_failure($sformatf("%s expected %0d got %0d", FieldName[k],
								due_field[k], seen_field[k]));
						end
					end
				end
			end
			if (in_valid && in_ready) wheels_due.push_back(wheel_word_for(in_data, band_copy));
			if (cfg_wr_en) band_copy = cfg_wr_data;
		end
		words_owed = wheels_due.size();
	end

endmodule

[tb/sv/mecanum_joystick_wheel_mixer_tb.sv]
// ----------------------------------------------------------------------------
// mecanum_joystick_wheel_mixer_tb
// Drives joystick words into the mecanum mixer under several dead band
// settings, with random gaps on the input and random stalls on the output,
// and leaves prediction and comparison to the wheel checker beside the block.
// ----------------------------------------------------------------------------
module mecanum_joystick_wheel_mixer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mjwm_pkg::*;

	localparam int IdleLimit = 2000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_wr_en = 1'b0;
	logic [6:0] cfg_wr_data = '0;
	logic       calm = 1'b0;
	int         mismatches;
	int         words_owed;
	int         stall_left = 0;
	int         idle_cycles = 0;

	mecanum_joystick_wheel_mixer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	mjwm_wheel_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mismatches (mismatches),
		.words_owed (words_owed)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Output stalls come in random bursts, none once the run calms down.
	always @(posedge clk) begin
		if (calm) begin
			stall_left <= 0;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: too long without any word moving on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Offer one joystick word, sometimes after a gap, and wait for its handshake.
	task automatic send_sample(input logic [7:0] x, input logic [7:0] y, input logic [7:0] t);
		in_item_t s;
		int       gap;
		s.stick_x = x;
		s.stick_y = y;
		s.stick_turn = t;
		if (!calm && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drain the block, let the pipeline settle, then write the dead band.
	// The checker counts the last accepted word at the clock edge, so the
	// owed count is read only from the falling edge on.
	task automatic set_dead_band(input logic [6:0] band);
		in_valid <= 1'b0;
		@(negedge clk);
		while (words_owed != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= band;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random stick byte, weighted toward the dead band edges and the extremes.
	function automatic logic [7:0] pick_stick_byte(logic [6:0] band);
		int v;
		int b;
		b = band;
		case ($urandom_range(0, 5))
			3: v = 127 - b + int'($urandom_range(0, 2)) - 1;
			4: v = 127 + b + int'($urandom_range(0, 2)) - 1;
			5: begin
				case ($urandom_range(0, 5))
					0: v = 0;
					1: v = 1;
					2: v = 126;
					3: v = 128;
					4: v = 254;
					default: v = 255;
				endcase
			end
			default: v = $urandom_range(0, 255);
		endcase
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	// One phase of random joystick words under a fresh dead band.
	task automatic run_random(input logic [6:0] band, input int count);
		set_dead_band(band);
		repeat (count) send_sample(pick_stick_byte(band), pick_stick_byte(band),
			pick_stick_byte(band));
	endtask

	// Stimulus and verdict.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset dead band: rest, extremes, overflow and the band edges.
		send_sample(8'd127, 8'd127, 8'd127);
		send_sample(8'd117, 8'd137, 8'd127);
		send_sample(8'd118, 8'd136, 8'd118);
		send_sample(8'd137, 8'd117, 8'd137);
		send_sample(8'd136, 8'd118, 8'd136);
		send_sample(8'd0, 8'd0, 8'd0);
		send_sample(8'd255, 8'd255, 8'd255);
		send_sample(8'd255, 8'd0, 8'd127);
		send_sample(8'd0, 8'd255, 8'd127);
		send_sample(8'd127, 8'd127, 8'd0);
		send_sample(8'd127, 8'd127, 8'd255);
		send_sample(8'd255, 8'd127, 8'd127);
		send_sample(8'd127, 8'd0, 8'd127);
		send_sample(8'd0, 8'd127, 8'd255);
		send_sample(8'd255, 8'd255, 8'd0);
		send_sample(8'd200, 8'd60, 8'd90);
		send_sample(8'd60, 8'd200, 8'd170);

		// No dead zone at all: one step off centre already moves the wheels.
		set_dead_band(7'd0);
		send_sample(8'd127, 8'd127, 8'd127);
		send_sample(8'd126, 8'd128, 8'd127);
		send_sample(8'd128, 8'd126, 8'd0);

		// Widest dead zone: only 0, 254 and 255 get out.
		set_dead_band(7'd127);
		send_sample(8'd0, 8'd254, 8'd255);
		send_sample(8'd255, 8'd1, 8'd253);
		send_sample(8'd254, 8'd0, 8'd127);

		run_random(7'd10, 260);
		run_random(7'd0, 240);
		run_random(7'd127, 240);
		run_random(7'($urandom_range(2, 125)), 260);
		run_random(7'd1, 240);
		run_random(7'd126, 220);
		run_random(7'($urandom_range(2, 125)), 240);

		// Last stretch runs at full rate on both sides.
		calm <= 1'b1;
		run_random(7'($urandom_range(0, 127)), 260);

		in_valid <= 1'b0;
		@(negedge clk);
		while (words_owed != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && words_owed == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
